// File: sv/sibs_pkg.sv
// Shared types, sizes and codes for the sorted insert / binary search core.
// No dependencies; used by sibs_store and sorted_insert_binary_search_core.
`default_nettype none
package sibs_pkg;

    localparam int DEPTH  = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam int OPC_W  = 2;
    localparam int VAL_W  = 8;
    localparam int STS_W  = 2;
    localparam int POS_W  = 5;
    localparam int ECNT_W = 6;

    localparam logic [OPC_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OPC_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OPC_W-1:0] OP_SEARCH = 2'd2;

    localparam logic [STS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STS_W-1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [OPC_W-1:0]        opcode;
        logic signed [VAL_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [STS_W-1:0]  status;
        logic [POS_W-1:0]  position;
        logic [ECNT_W-1:0] entry_count;
    } out_item_t;

    // store access issued by the sequencer each cycle
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [VAL_W-1:0]  wr_data;
        logic [ADDR_W-1:0] rd_addr;
    } mem_req_t;

endpackage
`default_nettype wire

// File: sv/sibs_store.sv
// Entry store: one write port, one read port with registered read data.
// Depends on sibs_pkg.
`default_nettype none
module sibs_store (
    input  wire logic                          aclk,
    input  wire sibs_pkg::mem_req_t            req,
    output logic [sibs_pkg::VAL_W-1:0]         rd_data
);

    logic [sibs_pkg::VAL_W-1:0] mem [sibs_pkg::DEPTH];
    logic [sibs_pkg::VAL_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        rd_data_reg <= mem[req.rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// File: sv/sorted_insert_binary_search_core.sv
// Sorted store of signed bytes with insertion and binary search.
// Depends on sibs_pkg and sibs_store.
//
//  channel | dir | handshake        | payload
//  s_      | in  | s_valid/s_ready  | s_data  (opcode, value)
//  m_      | out | m_valid/m_ready  | m_data  (status, position, entry_count)
//
// Clear, unused opcode and full append go straight to the finish state. Append:
// one shifted entry per cycle through the store's single read and write port.
// Search: each probe is a registered store read, then a compare; up to
// log2(DEPTH)+1 probes. aresetn empties the store (count only).
// s_ready is high only in idle; a result waiting on m_ready holds the next item
// in its finish state, so one new item can be worked on meanwhile.
`default_nettype none
module sorted_insert_binary_search_core (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire sibs_pkg::in_item_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output sibs_pkg::out_item_t      m_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INS  = 3'd1;
    localparam logic [2:0] S_SRD  = 3'd2;
    localparam logic [2:0] S_SCMP = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]                        state_reg, state_next;
    logic [sibs_pkg::CNT_W-1:0]        count_reg, count_next;
    logic signed [sibs_pkg::VAL_W-1:0] key_reg, key_next;
    logic [sibs_pkg::ADDR_W-1:0]       pos_reg, pos_next;
    logic [sibs_pkg::CNT_W-1:0]        lo_reg, lo_next;
    logic [sibs_pkg::CNT_W-1:0]        hi_reg, hi_next;   // right + 1
    logic [sibs_pkg::ADDR_W-1:0]       mid_reg, mid_next;
    sibs_pkg::out_item_t               res_reg, res_next;
    sibs_pkg::out_item_t               m_data_reg, m_data_next;
    logic                              m_valid_reg, m_valid_next;

    sibs_pkg::mem_req_t                req;
    logic [sibs_pkg::VAL_W-1:0]        rd_data;
    logic signed [sibs_pkg::VAL_W-1:0] entry;
    logic [sibs_pkg::CNT_W-1:0]        mid_full;
    logic [sibs_pkg::CNT_W-1:0]        count_inc;

    sibs_store u_store (
        .aclk    (aclk),
        .req     (req),
        .rd_data (rd_data)
    );

    assign entry     = $signed(rd_data);
    assign mid_full  = lo_reg + ((hi_reg - lo_reg - sibs_pkg::CNT_W'(1)) >> 1);
    assign count_inc = count_reg + sibs_pkg::CNT_W'(1);

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        key_next     = key_reg;
        pos_next     = pos_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        res_next     = res_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;
        req.wr_en    = 1'b0;
        req.wr_addr  = pos_reg;
        req.wr_data  = key_reg;
        req.rd_addr  = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    key_next             = s_data.value;
                    res_next.status      = sibs_pkg::ST_OK;
                    res_next.position    = '0;
                    res_next.entry_count = sibs_pkg::ECNT_W'(count_reg);
                    state_next           = S_FIN;
                    priority if (s_data.opcode == sibs_pkg::OP_CLEAR) begin
                        count_next           = '0;
                        res_next.entry_count = '0;
                    end else if (s_data.opcode == sibs_pkg::OP_APPEND) begin
                        if (count_reg >= sibs_pkg::CNT_W'(sibs_pkg::DEPTH)) begin
                            res_next.status = sibs_pkg::ST_FULL;
                        end else begin
                            pos_next    = sibs_pkg::ADDR_W'(count_reg);
                            req.rd_addr = sibs_pkg::ADDR_W'(count_reg - sibs_pkg::CNT_W'(1));
                            state_next  = S_INS;
                        end
                    end else if (s_data.opcode == sibs_pkg::OP_SEARCH) begin
                        lo_next    = '0;
                        hi_next    = count_reg;
                        state_next = S_SRD;
                    end else begin
                        // unused opcode: no change
                    end
                end
            end
            S_INS: begin
                // rd_data holds entry pos_reg-1; next lower entry is read speculatively
                req.rd_addr = pos_reg - sibs_pkg::ADDR_W'(2);
                if (pos_reg != '0 && key_reg < entry) begin
                    req.wr_en   = 1'b1;
                    req.wr_data = rd_data;
                    pos_next    = pos_reg - sibs_pkg::ADDR_W'(1);
                end else begin
                    req.wr_en            = 1'b1;
                    count_next           = count_inc;
                    res_next.status      = sibs_pkg::ST_OK;
                    res_next.position    = sibs_pkg::POS_W'(pos_reg);
                    res_next.entry_count = sibs_pkg::ECNT_W'(count_inc);
                    state_next           = S_FIN;
                end
            end
            S_SRD: begin
                if (hi_reg > lo_reg) begin
                    mid_next    = sibs_pkg::ADDR_W'(mid_full);
                    req.rd_addr = sibs_pkg::ADDR_W'(mid_full);
                    state_next  = S_SCMP;
                end else begin
                    res_next.status   = sibs_pkg::ST_NOT_FOUND;
                    res_next.position = '0;
                    state_next        = S_FIN;
                end
            end
            S_SCMP: begin
                priority if (entry == key_reg) begin
                    res_next.status   = sibs_pkg::ST_OK;
                    res_next.position = sibs_pkg::POS_W'(mid_reg);
                    state_next        = S_FIN;
                end else if (entry < key_reg) begin
                    lo_next    = sibs_pkg::CNT_W'(mid_reg) + sibs_pkg::CNT_W'(1);
                    state_next = S_SRD;
                end else begin
                    hi_next    = sibs_pkg::CNT_W'(mid_reg);
                    state_next = S_SRD;
                end
            end
            S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg    <= key_next;
        pos_reg    <= pos_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

endmodule
`default_nettype wire
